/* rtl/core/mfs_pkg.sv */
package mfs_pkg;

    localparam int SAMPLE_W          = 8;
    localparam int DIM_W             = 13;
    localparam int CC_W              = 3;
    localparam int IN_ROW_W          = DIM_W + 1;
    localparam int BANKS             = 4;
    localparam int BANK_W            = 2;
    localparam int WIN_ROWS          = 5;
    localparam int WIN_N             = WIN_ROWS * WIN_ROWS;
    localparam int MED_IDX           = 12;
    localparam int NET_STEPS         = 113;
    localparam int CHUNK             = 8;
    localparam int NET_STAGES        = (NET_STEPS + CHUNK - 1) / CHUNK;
    localparam int PADDR_W           = 4;
    localparam int PDATA_W           = 32;
    localparam int MAX_ROW_BYTES_DEF = 4096;
    localparam int MAX_CHANNELS_DEF  = 4;
    localparam int WIDTH_RST         = 640;
    localparam int HEIGHT_RST        = 480;
    localparam int CHAN_RST          = 1;

    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef t_sample [WIN_N-1:0] t_win;

    typedef struct packed {
        logic produce;
        logic border;
        logic frame_end;
    } t_ctl;

    localparam int NET_A [NET_STEPS] = '{
        1, 0, 1, 4, 3, 4, 0, 2, 2, 1,
        1, 3, 7, 6, 7, 10, 9, 10, 6, 8,
        8, 7, 7, 9, 0, 4, 4, 2, 2, 6,
        1, 5, 5, 3, 3, 7, 1, 3, 5, 7,
        9, 13, 12, 13, 16, 15, 16, 12, 14, 14,
        13, 13, 15, 19, 18, 19, 21, 23, 21, 22,
        22, 18, 20, 20, 19, 22, 19, 21, 23, 12,
        16, 16, 14, 20, 14, 18, 22, 13, 17, 17,
        15, 15, 19, 13, 15, 17, 19, 21, 23, 0,
        8, 8, 4, 16, 12, 2, 10, 10, 6, 6,
        10, 1, 9, 9, 5, 13, 3, 11, 11, 7,
        7, 11, 11
    };

    localparam int NET_B [NET_STEPS] = '{
        2, 1, 2, 5, 4, 5, 3, 5, 3, 4,
        2, 4, 8, 7, 8, 11, 10, 11, 9, 11,
        9, 10, 8, 10, 6, 10, 6, 8, 4, 8,
        7, 11, 7, 9, 5, 9, 2, 4, 6, 8,
        10, 14, 13, 14, 17, 16, 17, 15, 17, 15,
        16, 14, 16, 20, 19, 20, 22, 24, 23, 24,
        23, 21, 23, 21, 22, 24, 20, 22, 24, 18,
        22, 18, 20, 24, 16, 20, 24, 19, 23, 19,
        21, 17, 21, 14, 16, 18, 20, 22, 24, 12,
        20, 12, 16, 24, 16, 14, 22, 14, 18, 10,
        12, 13, 21, 13, 17, 17, 15, 23, 15, 19,
        11, 13, 12
    };

    function automatic t_win net_chunk(input t_win w, input int first);
        t_win    p;
        t_sample a;
        t_sample b;
        p = w;
        for (int i = 0; i < CHUNK; i++) begin
            if (first + i < NET_STEPS) begin
                a = p[NET_A[first + i]];
                b = p[NET_B[first + i]];
                p[NET_A[first + i]] = (a < b) ? a : b;
                p[NET_B[first + i]] = (a < b) ? b : a;
            end
        end
        return p;
    endfunction

endpackage

/* rtl/core/mfs_ram.sv */
module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* rtl/core/mfs_window.sv */
module mfs_window #(
    parameter int MAX_ROW_BYTES = mfs_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_CHANNELS  = mfs_pkg::MAX_CHANNELS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  logic                               i_step,
    input  mfs_pkg::t_sample                   i_sample,
    input  logic [$clog2(MAX_ROW_BYTES)-1:0]   i_col,
    input  logic [$clog2(MAX_ROW_BYTES)-1:0]   i_bcol,
    input  logic [mfs_pkg::BANK_W-1:0]         i_wbank,
    input  logic [mfs_pkg::BANK_W-1:0]         i_bbank,
    input  logic [$clog2(MAX_CHANNELS+1)-1:0]  i_ch,
    input  mfs_pkg::t_ctl                      i_ctl,
    output logic                               o_valid,
    output mfs_pkg::t_ctl                      o_ctl,
    output mfs_pkg::t_win                      o_win,
    output mfs_pkg::t_sample                   o_bval
);

    localparam int CHW   = $clog2(MAX_CHANNELS + 1);
    localparam int TAP_N = 4 * MAX_CHANNELS + 1;
    localparam int ROWS  = mfs_pkg::WIN_ROWS;

    mfs_pkg::t_sample rd_a [mfs_pkg::BANKS];
    mfs_pkg::t_sample rd_b [mfs_pkg::BANKS];

    logic                          r_s1_valid;
    mfs_pkg::t_ctl                 r_s1_ctl;
    mfs_pkg::t_sample              r_s1_v;
    logic [mfs_pkg::BANK_W-1:0]    r_s1_base;
    logic [mfs_pkg::BANK_W-1:0]    r_s1_bbank;
    logic [CHW-1:0]                r_s1_ch;

    mfs_pkg::t_sample r_taps [ROWS][TAP_N];
    mfs_pkg::t_sample n_taps [ROWS][TAP_N];
    mfs_pkg::t_sample col_new [ROWS];
    mfs_pkg::t_win    win;

    logic             r_s2_valid;
    mfs_pkg::t_ctl    r_s2_ctl;
    mfs_pkg::t_win    r_s2_win;
    mfs_pkg::t_sample r_s2_bval;

    for (genvar g = 0; g < mfs_pkg::BANKS; g++) begin : g_bank
        mfs_ram #(
            .WIDTH(mfs_pkg::SAMPLE_W),
            .DEPTH(MAX_ROW_BYTES)
        ) u_ram (
            .i_clk     (i_clk),
            .i_we      (i_step && (i_wbank == mfs_pkg::BANK_W'(g))),
            .i_waddr   (i_col),
            .i_wdata   (i_sample),
            .i_re      (i_adv),
            .i_raddr_a (i_col),
            .i_raddr_b (i_bcol),
            .o_rdata_a (rd_a[g]),
            .o_rdata_b (rd_b[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_ctl   <= i_ctl;
            r_s1_v     <= i_sample;
            r_s1_base  <= i_wbank;
            r_s1_bbank <= i_bbank;
            r_s1_ch    <= i_ch;
        end
    end

    always_comb begin
        for (int k = 0; k < ROWS - 1; k++) begin
            col_new[k] = rd_a[mfs_pkg::BANK_W'(r_s1_base + mfs_pkg::BANK_W'(k))];
        end
        col_new[ROWS-1] = r_s1_v;
    end

    always_comb begin
        for (int k = 0; k < ROWS; k++) begin
            n_taps[k][0] = col_new[k];
            for (int i = 1; i < TAP_N; i++) begin
                n_taps[k][i] = r_taps[k][i-1];
            end
        end
    end

    always_comb begin
        win = '0;
        for (int k = 0; k < ROWS; k++) begin
            for (int j = 0; j < ROWS; j++) begin
                for (int c = 1; c <= MAX_CHANNELS; c++) begin
                    if (r_s1_ch == CHW'(c)) begin
                        win[ROWS*k + j] = n_taps[k][(ROWS - 1 - j) * c];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && r_s1_valid) begin
            r_taps <= n_taps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_adv) begin
            r_s2_valid <= r_s1_valid && r_s1_ctl.produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2_ctl  <= r_s1_ctl;
            r_s2_win  <= win;
            r_s2_bval <= rd_b[r_s1_bbank];
        end
    end

    assign o_valid = r_s2_valid;
    assign o_ctl   = r_s2_ctl;
    assign o_win   = r_s2_win;
    assign o_bval  = r_s2_bval;

endmodule

/* rtl/core/mfs_sort.sv */
module mfs_sort (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  mfs_pkg::t_ctl    i_ctl,
    input  mfs_pkg::t_win    i_win,
    input  mfs_pkg::t_sample i_bval,
    output logic             o_valid,
    output mfs_pkg::t_ctl    o_ctl,
    output mfs_pkg::t_sample o_value
);

    localparam int NS = mfs_pkg::NET_STAGES;

    logic             r_valid [NS];
    mfs_pkg::t_ctl    r_ctl   [NS];
    mfs_pkg::t_win    r_win   [NS];
    mfs_pkg::t_sample r_bval  [NS];

    for (genvar g = 0; g < NS; g++) begin : g_stage
        if (g == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[g] <= 1'b0;
                end else if (i_adv) begin
                    r_valid[g] <= i_valid;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_ctl[g]  <= i_ctl;
                    r_win[g]  <= mfs_pkg::net_chunk(i_win, 0);
                    r_bval[g] <= i_bval;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[g] <= 1'b0;
                end else if (i_adv) begin
                    r_valid[g] <= r_valid[g-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_ctl[g]  <= r_ctl[g-1];
                    r_win[g]  <= mfs_pkg::net_chunk(r_win[g-1], g * mfs_pkg::CHUNK);
                    r_bval[g] <= r_bval[g-1];
                end
            end
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_ctl   = r_ctl[NS-1];
    assign o_value = r_ctl[NS-1].border ? r_bval[NS-1] : r_win[NS-1][mfs_pkg::MED_IDX];

endmodule

/* rtl/core/median_filter_5x5_stream_top.sv */
// channel   | dir | handshake          | payload
// input     | in  | i_valid / o_stall  | i_sample, i_flush
// result    | out | o_valid / i_stall  | o_filtered, o_frame_end
// config    | in  | APB psel/penable   | paddr, pwdata, prdata
//
// One beat is taken every cycle unless o_stall is high; the row store banks are read and written
// in the cycle of the beat, with one read of each bank per neighbor row and one border read.
// A beat passes through the row store read, the window and 15 sorting stages to its result.
// Results appear 2 rows plus 2 pixels after their sample; flush beats drain the tail.
// Reset is synchronous and clears control only; the row store needs no clearing pass.
// A stalled result holds the pipeline only when a result waits behind it.
module median_filter_5x5_stream_top #(
    parameter int MAX_ROW_BYTES = mfs_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_CHANNELS  = mfs_pkg::MAX_CHANNELS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [mfs_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                         i_flush,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [mfs_pkg::SAMPLE_W-1:0] o_filtered,
    output logic                         o_frame_end,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mfs_pkg::PADDR_W-1:0]  paddr,
    input  logic [mfs_pkg::PDATA_W-1:0]  pwdata,
    output logic [mfs_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int CW  = $clog2(MAX_ROW_BYTES);
    localparam int LW  = $clog2(MAX_ROW_BYTES + 1);
    localparam int CHW = $clog2(MAX_CHANNELS + 1);
    localparam int DW  = mfs_pkg::DIM_W;
    localparam int RW  = mfs_pkg::IN_ROW_W;
    localparam int PW  = RW + LW;

    function automatic logic [CHW-1:0] clamp_ch(input logic [mfs_pkg::CC_W-1:0] x);
        logic [CHW-1:0] y;
        if (x == '0) begin
            y = CHW'(1);
        end else if (int'(x) > MAX_CHANNELS) begin
            y = CHW'(MAX_CHANNELS);
        end else begin
            y = CHW'(x);
        end
        return y;
    endfunction

    function automatic logic [LW-1:0] len_of(input logic [DW-1:0] w, input logic [CHW-1:0] c);
        logic [DW+CHW-1:0] prod;
        logic [LW-1:0]     y;
        prod = (DW+CHW)'((w == '0) ? DW'(1) : w) * (DW+CHW)'(c);
        if (int'(prod) > MAX_ROW_BYTES) begin
            y = LW'(MAX_ROW_BYTES);
        end else begin
            y = LW'(prod);
        end
        return y;
    endfunction

    logic [DW-1:0]              r_cfg_w;
    logic [DW-1:0]              r_cfg_h;
    logic [mfs_pkg::CC_W-1:0]   r_cfg_c;
    logic [LW-1:0]              r_len;
    logic [DW-1:0]              r_h;
    logic [CHW-1:0]             r_ch;

    logic [CW-1:0] r_in_col,  n_in_col;
    logic [RW-1:0] r_in_row,  n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [DW-1:0] r_out_row, n_out_row;

    logic                   cfg_wr;
    logic                   adv;
    logic                   accept;
    logic                   in_frame;
    logic                   step;
    mfs_pkg::t_sample       v;
    logic [PW-1:0]          pos;
    logic [LW+1:0]          dly;
    logic                   col_last;
    logic                   ocol_last;
    logic                   orow_last;
    mfs_pkg::t_ctl          ctl;

    logic             win_valid;
    mfs_pkg::t_ctl    win_ctl;
    mfs_pkg::t_win    win_data;
    mfs_pkg::t_sample win_bval;
    logic             sort_valid;
    mfs_pkg::t_ctl    sort_ctl;
    mfs_pkg::t_sample sort_value;

    logic             r_out_valid;
    mfs_pkg::t_sample r_out_val;
    logic             r_out_fe;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= DW'(mfs_pkg::WIDTH_RST);
            r_cfg_h <= DW'(mfs_pkg::HEIGHT_RST);
            r_cfg_c <= mfs_pkg::CC_W'(mfs_pkg::CHAN_RST);
            r_h     <= DW'(mfs_pkg::HEIGHT_RST);
            r_ch    <= clamp_ch(mfs_pkg::CC_W'(mfs_pkg::CHAN_RST));
            r_len   <= len_of(DW'(mfs_pkg::WIDTH_RST),
                              clamp_ch(mfs_pkg::CC_W'(mfs_pkg::CHAN_RST)));
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                mfs_pkg::REG_IMAGE_WIDTH: begin
                    r_cfg_w <= pwdata[DW-1:0];
                    r_len   <= len_of(pwdata[DW-1:0], r_ch);
                end
                mfs_pkg::REG_IMAGE_HEIGHT: begin
                    r_cfg_h <= pwdata[DW-1:0];
                    r_h     <= (pwdata[DW-1:0] == '0) ? DW'(1) : pwdata[DW-1:0];
                end
                mfs_pkg::REG_CHANNEL_COUNT: begin
                    r_cfg_c <= pwdata[mfs_pkg::CC_W-1:0];
                    r_ch    <= clamp_ch(pwdata[mfs_pkg::CC_W-1:0]);
                    r_len   <= len_of(r_cfg_w, clamp_ch(pwdata[mfs_pkg::CC_W-1:0]));
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            mfs_pkg::REG_IMAGE_WIDTH:   prdata = mfs_pkg::PDATA_W'(r_cfg_w);
            mfs_pkg::REG_IMAGE_HEIGHT:  prdata = mfs_pkg::PDATA_W'(r_cfg_h);
            mfs_pkg::REG_CHANNEL_COUNT: prdata = mfs_pkg::PDATA_W'(r_cfg_c);
            default:                    prdata = '0;
        endcase
    end

    assign adv     = !(r_out_valid && i_stall && sort_valid);
    assign o_stall = !adv;
    assign accept  = i_valid && adv;

    assign in_frame = r_in_row < RW'(r_h);
    assign step     = accept && !(in_frame && i_flush);
    assign v        = in_frame ? i_sample : '0;

    assign pos = PW'(r_in_row) * PW'(r_len) + PW'(r_in_col);
    assign dly = (LW+2)'({r_len, 1'b0}) + (LW+2)'({r_ch, 1'b0});

    assign col_last  = (LW+1)'(r_in_col) + (LW+1)'(1) >= (LW+1)'(r_len);
    assign ocol_last = (LW+1)'(r_out_col) + (LW+1)'(1) >= (LW+1)'(r_len);
    assign orow_last = RW'(r_out_row) + RW'(1) >= RW'(r_h);

    always_comb begin
        ctl.produce   = pos >= PW'(dly);
        ctl.border    = (r_out_row < DW'(2))
                     || (RW'(r_out_row) + RW'(2) >= RW'(r_h))
                     || ((LW+1)'(r_out_col) < (LW+1)'({r_ch, 1'b0}))
                     || ((LW+1)'(r_out_col) + (LW+1)'({r_ch, 1'b0}) >= (LW+1)'(r_len));
        ctl.frame_end = ctl.produce && ocol_last && orow_last;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (step) begin
            if (col_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + RW'(1);
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
            if (ctl.produce) begin
                if (ocol_last) begin
                    if (orow_last) begin
                        n_in_col  = '0;
                        n_in_row  = '0;
                        n_out_col = '0;
                        n_out_row = '0;
                    end else begin
                        n_out_col = '0;
                        n_out_row = r_out_row + DW'(1);
                    end
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    mfs_window #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_step   (step),
        .i_sample (v),
        .i_col    (r_in_col),
        .i_bcol   (r_out_col),
        .i_wbank  (r_in_row[mfs_pkg::BANK_W-1:0]),
        .i_bbank  (r_out_row[mfs_pkg::BANK_W-1:0]),
        .i_ch     (r_ch),
        .i_ctl    (ctl),
        .o_valid  (win_valid),
        .o_ctl    (win_ctl),
        .o_win    (win_data),
        .o_bval   (win_bval)
    );

    mfs_sort u_sort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (win_valid),
        .i_ctl   (win_ctl),
        .i_win   (win_data),
        .i_bval  (win_bval),
        .o_valid (sort_valid),
        .o_ctl   (sort_ctl),
        .o_value (sort_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && sort_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && sort_valid) begin
            r_out_val <= sort_value;
            r_out_fe  <= sort_ctl.frame_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_filtered  = r_out_val;
    assign o_frame_end = r_out_fe;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_keeps_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> o_valid && sort_valid)
        else $error("pipeline moved while blocked");

    a_frame_end_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && ctl.frame_end |=> r_in_col == '0 && r_in_row == '0
                                  && r_out_col == '0 && r_out_row == '0)
        else $error("positions not rewound at frame end");

endmodule

/* tb/sv/median_filter_5x5_stream_top_test.sv */
`timescale 1ns / 100ps

class median_scoreboard;

    typedef struct {
        logic [7:0] filtered;
        logic       frame_end;
    } pixel_result_t;

    int unsigned   chans;
    int unsigned   rows;
    int unsigned   row_len;
    int unsigned   in_col;
    int unsigned   in_row;
    int unsigned   out_col;
    int unsigned   out_row;
    bit [7:0]      frame_img[int];
    pixel_result_t due_q[$];
    int            errors;

    function new();
        errors = 0;
        set_geometry(mfs_pkg::WIDTH_RST, mfs_pkg::HEIGHT_RST, mfs_pkg::CHAN_RST);
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function void set_geometry(int unsigned w, int unsigned h, int unsigned c);
        int unsigned wm;
        wm    = (w & 13'h1fff) == 0 ? 1 : (w & 13'h1fff);
        rows  = (h & 13'h1fff) == 0 ? 1 : (h & 13'h1fff);
        chans = (c & 3'h7) == 0 ? 1 : ((c & 3'h7) > 4 ? 4 : (c & 3'h7));
        row_len = wm * chans > 4096 ? 4096 : wm * chans;
    endfunction

    function int unsigned drain_len();
        return 2 * row_len + 2 * chans;
    endfunction

    function bit [7:0] median_at(int unsigned r, int unsigned c);
        bit [7:0] p[25];
        bit [7:0] a;
        bit [7:0] b;
        for (int k = 0; k < 5; k++)
            for (int j = 0; j < 5; j++)
                p[5 * k + j] = frame_img[(r - 2 + k) * row_len + c + j * chans - 2 * chans];
        for (int s = 0; s < mfs_pkg::NET_STEPS; s++) begin
            a = p[mfs_pkg::NET_A[s]];
            b = p[mfs_pkg::NET_B[s]];
            p[mfs_pkg::NET_A[s]] = a < b ? a : b;
            p[mfs_pkg::NET_B[s]] = a < b ? b : a;
        end
        return p[mfs_pkg::MED_IDX];
    endfunction

    function void note_beat(bit [7:0] sample, bit flush);
        pixel_result_t r;
        bit            in_frame;
        bit            border;
        in_frame = in_row < rows;
        if (in_frame && flush)
            return;
        if (in_frame)
            frame_img[in_row * row_len + in_col] = sample;
        if (in_row * row_len + in_col >= 2 * row_len + 2 * chans) begin
            border = out_row < 2 || out_row + 2 >= rows ||
                     out_col < 2 * chans || out_col + 2 * chans >= row_len;
            r.filtered  = border ? frame_img[out_row * row_len + out_col]
                                 : median_at(out_row, out_col);
            r.frame_end = 1'b0;
            in_col++;
            if (in_col >= row_len) begin
                in_col = 0;
                in_row++;
            end
            if (out_col + 1 >= row_len) begin
                if (out_row + 1 >= rows) begin
                    r.frame_end = 1'b1;
                    in_col  = 0;
                    in_row  = 0;
                    out_col = 0;
                    out_row = 0;
                    frame_img.delete();
                end else begin
                    out_col = 0;
                    out_row++;
                end
            end else begin
                out_col++;
            end
            due_q.push_back(r);
        end else begin
            in_col++;
            if (in_col >= row_len) begin
                in_col = 0;
                in_row++;
            end
        end
    endfunction

    function void check_result(logic [7:0] filtered, logic frame_end);
        pixel_result_t r;
        if (due_q.size() == 0) begin
            $error("unexpected result: filtered %0d frame_end %0d", filtered, frame_end);
            errors++;
            return;
        end
        r = due_q.pop_front();
        if (filtered !== r.filtered) begin
            $error("filtered: expected %0d, actual %0d", r.filtered, filtered);
            errors++;
        end
        if (frame_end !== r.frame_end) begin
            $error("frame_end: expected %0d, actual %0d", r.frame_end, frame_end);
            errors++;
        end
    endfunction

endclass

module median_filter_5x5_stream_top_test;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_sample;
    logic        i_flush;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_filtered;
    logic        o_frame_end;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [mfs_pkg::PADDR_W-1:0] paddr;
    logic [mfs_pkg::PDATA_W-1:0] pwdata;
    logic [mfs_pkg::PDATA_W-1:0] prdata;
    logic        pready;

    median_scoreboard sb;
    int send_gap_pct;
    int recv_stall_pct;
    int sent_items;

    median_filter_5x5_stream_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_sample(i_sample), .i_flush(i_flush),
        .o_valid(o_valid), .i_stall(i_stall), .o_filtered(o_filtered),
        .o_frame_end(o_frame_end),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 900000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(negedge i_clk)
        i_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_filtered, o_frame_end);

    task automatic reg_write(logic [1:0] idx, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_beat(bit [7:0] sample, bit flush);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= sample;
        i_flush  <= flush;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_beat(sample, flush);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.due_q.size() != 0) @(negedge i_clk);
        repeat (24) @(negedge i_clk);
    endtask

    task automatic run_frame(int unsigned w, int unsigned h, int unsigned c, bit extremes);
        int unsigned total;
        int unsigned drain;
        bit [7:0]    s;
        reg_write(mfs_pkg::REG_IMAGE_WIDTH, w);
        reg_write(mfs_pkg::REG_IMAGE_HEIGHT, h);
        reg_write(mfs_pkg::REG_CHANNEL_COUNT, c);
        sb.set_geometry(w, h, c);
        total = sb.rows * sb.row_len;
        drain = sb.drain_len();
        for (int unsigned i = 0; i < total; i++) begin
            if (!extremes && $urandom_range(99) < 4)
                send_beat(8'($urandom_range(255)), 1'b1);
            if (extremes)
                s = (i % 3 == 0) ? 8'd0 : (i % 3 == 1) ? 8'd255 : 8'($urandom_range(255));
            else
                s = 8'($urandom_range(255));
            send_beat(s, 1'b0);
        end
        for (int unsigned i = 0; i < drain; i++)
            send_beat(8'($urandom_range(255)), 1'($urandom_range(1)));
        wait_idle();
    endtask

    task automatic random_frame();
        int unsigned w;
        int unsigned h;
        if ($urandom_range(3) != 0) begin
            w = $urandom_range(9, 5);
            h = $urandom_range(8, 5);
        end else begin
            w = $urandom_range(12, 1);
            h = $urandom_range(8, 1);
        end
        run_frame(w, h, $urandom_range(4, 1), 1'b0);
    endtask

    initial begin
        sb = new();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        sent_items     = 0;
        i_valid  = 1'b0;
        i_sample = '0;
        i_flush  = 1'b0;
        i_stall  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        i_rst_n  = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_frame(5, 5, 1, 1'b1);
        send_gap_pct   = 7;
        recv_stall_pct = 63;
        while (sent_items < 400) random_frame();
        send_gap_pct   = 63;
        recv_stall_pct = 7;
        while (sent_items < 750) random_frame();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        while (sent_items < 1050) random_frame();
        run_frame(0, 0, 0, 1'b0);
        run_frame(3, 6, 7, 1'b0);
        run_frame(1, 40, 1, 1'b0);
        run_frame(6, 6, 4, 1'b1);

        if (sb.due_q.size() != 0) begin
            $error("%0d expected results never arrived", sb.due_q.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* median_filter_5x5_stream_top.f */
rtl/core/mfs_pkg.sv
rtl/core/mfs_ram.sv
rtl/core/mfs_window.sv
rtl/core/mfs_sort.sv
rtl/core/median_filter_5x5_stream_top.sv
tb/sv/median_filter_5x5_stream_top_test.sv
